>>> rtl/core/fmbs_pkg.sv
// Package for the FM-index backward search core: command codes, controller
// states, command/status structs and the range clamp. No dependencies.
`timescale 1ns / 1ps
package fmbs_pkg;

    localparam int RANGE_W   = 17;
    localparam int POS_W     = 18;
    localparam int SUM_W     = 20;
    localparam int DIV_STEPS = 18;
    localparam int DCNT_W    = 5;
    localparam int SP_W      = 8;

    typedef enum logic [1:0] {
        CMD_LOAD_BWT    = 2'd0,
        CMD_LOAD_SAMPLE = 2'd1,
        CMD_START       = 2'd2,
        CMD_EXTEND      = 2'd3
    } fmbs_command_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SREAD,
        ST_SINIT,
        ST_SCAN,
        ST_OUT
    } fmbs_state_t;

    typedef enum logic [2:0] {
        REG_COUNT_A  = 3'd0,
        REG_COUNT_C  = 3'd1,
        REG_COUNT_G  = 3'd2,
        REG_COUNT_T  = 3'd3,
        REG_SPACING  = 3'd4
    } fmbs_reg_t;

    typedef struct packed {
        logic capture;
        logic load_bwt;
        logic load_smp;
        logic start_upd;
        logic div_start;
        logic phase;
        logic smp_read;
        logic scan_init;
        logic scan_step;
        logic save_low;
        logic ext_upd;
        logic out_load;
    } fmbs_cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic cur_empty;
    } fmbs_status_t;

    function automatic logic [RANGE_W-1:0] fmbs_clamp(input logic [SUM_W-1:0] v);
        logic [RANGE_W-1:0] r;
        if (v[SUM_W-1:RANGE_W] != '0) begin
            r = '1;
        end else begin
            r = v[RANGE_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/fmbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module fmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fmbs_ctrl.sv
// Controller state machine of the backward search core.
// Depends on fmbs_pkg; drives the datapath through fmbs_cmd_t.
`timescale 1ns / 1ps
module fmbs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  fmbs_pkg::fmbs_status_t st,
    output fmbs_pkg::fmbs_cmd_t  cmd
);

    fmbs_pkg::fmbs_state_t state_reg, state_next;
    logic phase_reg, phase_next;
    logic m_valid_reg, m_valid_next;
    logic accept;
    logic out_load;

    assign s_ready  = (state_reg == fmbs_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == fmbs_pkg::ST_OUT) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            fmbs_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (s_command == fmbs_pkg::CMD_START) begin
                        state_next = fmbs_pkg::ST_OUT;
                    end else if (s_command == fmbs_pkg::CMD_EXTEND) begin
                        phase_next = 1'b0;
                        state_next = st.cur_empty ? fmbs_pkg::ST_OUT : fmbs_pkg::ST_DIV;
                    end else begin
                        state_next = fmbs_pkg::ST_IDLE;
                    end
                end
            end
            fmbs_pkg::ST_DIV: begin
                if (st.div_done) begin
                    state_next = fmbs_pkg::ST_SREAD;
                end
            end
            fmbs_pkg::ST_SREAD: state_next = fmbs_pkg::ST_SINIT;
            fmbs_pkg::ST_SINIT: state_next = fmbs_pkg::ST_SCAN;
            fmbs_pkg::ST_SCAN: begin
                if (st.scan_done) begin
                    if (!phase_reg) begin
                        phase_next = 1'b1;
                        state_next = fmbs_pkg::ST_DIV;
                    end else begin
                        state_next = fmbs_pkg::ST_OUT;
                    end
                end
            end
            fmbs_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = fmbs_pkg::ST_IDLE;
                end
            end
            default: state_next = fmbs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.phase     = phase_reg;
        cmd.out_load  = out_load;
        cmd.capture   = accept;
        cmd.load_bwt  = accept && (s_command == fmbs_pkg::CMD_LOAD_BWT);
        cmd.load_smp  = accept && (s_command == fmbs_pkg::CMD_LOAD_SAMPLE);
        cmd.start_upd = accept && (s_command == fmbs_pkg::CMD_START);
        unique case (state_reg)
            fmbs_pkg::ST_IDLE: begin
                if (accept && s_command == fmbs_pkg::CMD_EXTEND && !st.cur_empty) begin
                    cmd.div_start = 1'b1;
                    cmd.phase     = 1'b0;
                end
            end
            fmbs_pkg::ST_SREAD: cmd.smp_read  = 1'b1;
            fmbs_pkg::ST_SINIT: cmd.scan_init = 1'b1;
            fmbs_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (st.scan_done) begin
                    if (!phase_reg) begin
                        cmd.save_low  = 1'b1;
                        cmd.div_start = 1'b1;
                        cmd.phase     = 1'b1;
                    end else begin
                        cmd.ext_upd = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fmbs_pkg::ST_IDLE;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTH
    a_low_then_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmbs_pkg::ST_SCAN && st.scan_done && !phase_reg)
        |=> (state_reg == fmbs_pkg::ST_DIV && phase_reg))
        else $error("second occurrence pass did not start");
    a_out_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid_reg && state_reg == fmbs_pkg::ST_IDLE))
        else $error("result load did not raise valid");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmbs_pkg::ST_OUT && m_valid_reg && !m_ready)
        |=> (state_reg == fmbs_pkg::ST_OUT))
        else $error("result overwritten under stall");
`endif

endmodule

>>> rtl/core/fmbs_datapath.sv
// Datapath of the backward search core: configuration registers, BWT and
// sample memories, serial divider, scan counter and range registers.
// Depends on fmbs_pkg and fmbs_ram.
`timescale 1ns / 1ps
module fmbs_datapath #(
    parameter int TEXT_ROWS   = 65536,
    parameter int SAMPLE_ROWS = 4096,
    parameter int MAX_SPACING = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_wr_data,
    input  logic [15:0]          s_address,
    input  logic [2:0]           s_symbol,
    input  logic [16:0]          s_sample_value,
    input  logic [1:0]           s_base,
    output logic [16:0]          m_range_low,
    output logic [16:0]          m_range_high,
    output logic                 m_is_empty,
    input  fmbs_pkg::fmbs_cmd_t  cmd,
    output fmbs_pkg::fmbs_status_t st
);

    localparam int BAW    = $clog2(TEXT_ROWS);
    localparam int SIW    = (SAMPLE_ROWS > 1) ? $clog2(SAMPLE_ROWS) : 1;
    localparam int SAW    = SIW + 2;
    localparam int SDEPTH = SAMPLE_ROWS * 4;

    logic [15:0] cnt_a_reg, cnt_c_reg, cnt_g_reg, cnt_t_reg;
    logic [7:0]  spacing_reg;
    logic [fmbs_pkg::SP_W-1:0] sp;
    logic [fmbs_pkg::POS_W-1:0] pfx [5];

    logic [1:0] base_reg;
    logic [fmbs_pkg::RANGE_W-1:0] cur_low_reg, cur_high_reg;
    logic [fmbs_pkg::RANGE_W-1:0] out_low_reg, out_high_reg;
    logic out_empty_reg;

    logic [fmbs_pkg::POS_W-1:0] occ_pos;
    logic [fmbs_pkg::POS_W-1:0] pos_reg, div_q_reg;
    logic [fmbs_pkg::SP_W-1:0]  div_r_reg;
    logic [fmbs_pkg::DCNT_W-1:0] div_cnt_reg;
    logic [fmbs_pkg::SP_W:0]    partial;
    logic idx_ok_reg;

    logic [fmbs_pkg::POS_W-1:0] scan_r_reg;
    logic [fmbs_pkg::SP_W-1:0]  left_reg;
    logic pend_reg, inrng_reg;
    logic [fmbs_pkg::POS_W-1:0] count_reg, occ_low_reg;

    logic [31:0] a32, q32, r32;
    logic bwt_we, smp_we;
    logic [BAW-1:0] bwt_waddr, bwt_raddr;
    logic [SAW-1:0] smp_waddr, smp_raddr;
    logic [2:0]  bwt_rdata;
    logic [16:0] smp_rdata;
    logic [fmbs_pkg::SUM_W-1:0] nl, nh, sl, sh;
    logic [2:0] sb1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg   <= '0;
            cnt_c_reg   <= '0;
            cnt_g_reg   <= '0;
            cnt_t_reg   <= '0;
            spacing_reg <= 8'd32;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fmbs_pkg::REG_COUNT_A: cnt_a_reg   <= cfg_wr_data;
                fmbs_pkg::REG_COUNT_C: cnt_c_reg   <= cfg_wr_data;
                fmbs_pkg::REG_COUNT_G: cnt_g_reg   <= cfg_wr_data;
                fmbs_pkg::REG_COUNT_T: cnt_t_reg   <= cfg_wr_data;
                fmbs_pkg::REG_SPACING: spacing_reg <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Effective spacing: zero acts as one, large values clip to the maximum.
    always_comb begin
        priority if (spacing_reg == 8'd0) begin
            sp = 8'd1;
        end else if (32'(spacing_reg) > 32'(MAX_SPACING)) begin
            sp = 8'(MAX_SPACING);
        end else begin
            sp = spacing_reg;
        end
    end

    assign pfx[0] = '0;
    assign pfx[1] = 18'(cnt_a_reg);
    assign pfx[2] = pfx[1] + 18'(cnt_c_reg);
    assign pfx[3] = pfx[2] + 18'(cnt_g_reg);
    assign pfx[4] = pfx[3] + 18'(cnt_t_reg);

    assign occ_pos = cmd.phase ? (18'(cur_high_reg) + 18'd1) : 18'(cur_low_reg);
    assign partial = {div_r_reg, div_q_reg[fmbs_pkg::POS_W-1]};

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_start) begin
            div_cnt_reg <= fmbs_pkg::DCNT_W'(fmbs_pkg::DIV_STEPS);
        end else if (div_cnt_reg != '0) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            pos_reg   <= occ_pos;
            div_q_reg <= occ_pos;
            div_r_reg <= '0;
        end else if (div_cnt_reg != '0) begin
            if (partial >= {1'b0, sp}) begin
                div_r_reg <= 8'(partial - {1'b0, sp});
                div_q_reg <= {div_q_reg[fmbs_pkg::POS_W-2:0], 1'b1};
            end else begin
                div_r_reg <= partial[fmbs_pkg::SP_W-1:0];
                div_q_reg <= {div_q_reg[fmbs_pkg::POS_W-2:0], 1'b0};
            end
        end
    end

    assign q32       = 32'(div_q_reg);
    assign smp_raddr = {q32[SIW-1:0], base_reg};
    assign r32       = 32'(scan_r_reg);
    assign bwt_raddr = r32[BAW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            base_reg <= s_base;
        end
        if (cmd.smp_read) begin
            idx_ok_reg <= (q32 < 32'(SAMPLE_ROWS));
        end
    end

    // Count matching BWT rows between the sample row and the position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            left_reg <= '0;
        end else if (cmd.scan_init) begin
            pend_reg <= 1'b0;
            left_reg <= div_r_reg;
        end else if (cmd.scan_step) begin
            if (left_reg != '0) begin
                pend_reg <= 1'b1;
                left_reg <= left_reg - 1'b1;
            end else begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            count_reg  <= idx_ok_reg ? 18'(smp_rdata) : '0;
            scan_r_reg <= pos_reg - 18'(div_r_reg);
        end else if (cmd.scan_step) begin
            if (left_reg != '0) begin
                inrng_reg  <= (r32 < 32'(TEXT_ROWS));
                scan_r_reg <= scan_r_reg + 1'b1;
            end
            if (pend_reg && inrng_reg && bwt_rdata == {1'b0, base_reg}) begin
                count_reg <= count_reg + 1'b1;
            end
        end
        if (cmd.save_low) begin
            occ_low_reg <= count_reg;
        end
    end

    assign st.div_done  = (div_cnt_reg == '0);
    assign st.scan_done = (left_reg == '0) && !pend_reg;
    assign st.cur_empty = (cur_low_reg > cur_high_reg);

    assign nl  = 20'(pfx[{1'b0, base_reg}]) + 20'(occ_low_reg) + 20'd1;
    assign nh  = 20'(pfx[{1'b0, base_reg}]) + 20'(count_reg);
    assign sb1 = {1'b0, s_base} + 3'd1;
    assign sl  = 20'(pfx[{1'b0, s_base}]) + 20'd1;
    assign sh  = 20'(pfx[sb1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_low_reg  <= '0;
            cur_high_reg <= '0;
        end else if (cmd.start_upd) begin
            cur_low_reg  <= fmbs_pkg::fmbs_clamp(sl);
            cur_high_reg <= fmbs_pkg::fmbs_clamp(sh);
        end else if (cmd.ext_upd) begin
            cur_low_reg  <= fmbs_pkg::fmbs_clamp(nl);
            cur_high_reg <= fmbs_pkg::fmbs_clamp(nh);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_low_reg   <= cur_low_reg;
            out_high_reg  <= cur_high_reg;
            out_empty_reg <= (cur_low_reg > cur_high_reg);
        end
    end

    assign m_range_low  = out_low_reg;
    assign m_range_high = out_high_reg;
    assign m_is_empty   = out_empty_reg;

    assign a32       = 32'(s_address);
    assign bwt_we    = cmd.load_bwt && (a32 < 32'(TEXT_ROWS));
    assign bwt_waddr = a32[BAW-1:0];
    assign smp_we    = cmd.load_smp && (a32 < 32'(SAMPLE_ROWS));
    assign smp_waddr = {a32[SIW-1:0], s_base};

    fmbs_ram #(.WIDTH(3), .DEPTH(TEXT_ROWS)) u_bwt_ram (
        .aclk  (aclk),
        .we    (bwt_we),
        .waddr (bwt_waddr),
        .wdata (s_symbol),
        .raddr (bwt_raddr),
        .rdata (bwt_rdata)
    );

    fmbs_ram #(.WIDTH(17), .DEPTH(SDEPTH)) u_smp_ram (
        .aclk  (aclk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (s_sample_value),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

endmodule

>>> rtl/core/fm_index_backward_search_core.sv
// Top level of the DNA FM-index backward search core.
// Depends on fmbs_pkg, fmbs_ctrl, fmbs_datapath and fmbs_ram.
`timescale 1ns / 1ps
// Usage:
// The request channel (s_valid/s_ready) carries four commands. Load BWT
// and load sample write one memory entry and return no result. Start
// opens the range for one base and returns it. Extend narrows the range
// by one earlier base and returns one result on the m_ valid/ready
// channel.
// An extend computes two occurrence counts one after the other. Each count
// runs a serial divider for position / spacing, a sample memory read, and
// a scan of the BWT memory one row per cycle over the remainder. An
// extend on an empty range returns the held range without a search.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wr_data) take effect at
// once and must be issued only while the core is idle.
// The result sits in an output register. While the receiver stalls, the
// core still accepts loads; a start or extend finishes and then waits
// until that register is free.
// Reset (aresetn, synchronous, active low) clears the range to zero, the
// counts to zero and the spacing to 32. Memory contents are undefined
// until loaded; no clearing pass is run.
module fm_index_backward_search_core #(
    parameter int TEXT_ROWS   = 65536,
    parameter int SAMPLE_ROWS = 4096,
    parameter int MAX_SPACING = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_address,
    input  logic [2:0]  s_symbol,
    input  logic [16:0] s_sample_value,
    input  logic [1:0]  s_base,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_range_low,
    output logic [16:0] m_range_high,
    output logic        m_is_empty
);

    fmbs_pkg::fmbs_cmd_t    cmd;
    fmbs_pkg::fmbs_status_t st;

    // The controller sequences each request; the datapath holds the configuration, memories and ranges.
    fmbs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .st        (st),
        .cmd       (cmd)
    );

    fmbs_datapath #(
        .TEXT_ROWS   (TEXT_ROWS),
        .SAMPLE_ROWS (SAMPLE_ROWS),
        .MAX_SPACING (MAX_SPACING)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_address      (s_address),
        .s_symbol       (s_symbol),
        .s_sample_value (s_sample_value),
        .s_base         (s_base),
        .m_range_low    (m_range_low),
        .m_range_high   (m_range_high),
        .m_is_empty     (m_is_empty),
        .cmd            (cmd),
        .st             (st)
    );

endmodule

>>> tb/fm_index_backward_search_core_test.sv
// Self-checking testbench for the DNA FM-index backward search core.
// Depends on fmbs_pkg and the fm_index_backward_search_core RTL.
`timescale 1ns / 1ps
module fm_index_backward_search_core_test;

    localparam int TEXT_ROWS   = 65536;
    localparam int SAMPLE_ROWS = 4096;
    localparam int MAX_SPACING = 128;
    localparam int NUM_BASES   = 4;
    localparam int RANGE_MAX   = 131071;
    // Length of the small indexed text that queries walk over.
    localparam int TEXT_LEN    = 64;
    // Cycles without any accepted request or result before giving up.
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        fmbs_pkg::fmbs_command_t command;
        logic [15:0]   address;
        logic [2:0]    symbol;
        logic [16:0]   sample_value;
        logic [1:0]    base;
    } search_req_t;

    typedef struct {
        logic [16:0] range_low;
        logic [16:0] range_high;
        logic        is_empty;
    } range_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [15:0] s_address;
    logic [2:0]  s_symbol;
    logic [16:0] s_sample_value;
    logic [1:0]  s_base;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [16:0] m_range_low;
    logic [16:0] m_range_high;
    logic        m_is_empty;

    // Mirror of the core: memories with written flags, range and registers.
    logic [2:0]  bwt_sym [TEXT_ROWS];
    bit          bwt_written [TEXT_ROWS];
    logic [16:0] occ_val [SAMPLE_ROWS * NUM_BASES];
    bit          occ_written [SAMPLE_ROWS * NUM_BASES];
    int unsigned cur_low, cur_high;
    int unsigned base_count [NUM_BASES];
    int unsigned spacing_reg;

    range_result_t expected_ranges[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          steady_flow = 1'b0;   // suppresses random idling on both sides
    int          hold_request = 0;     // receiver hold-off length, picked up below
    int          hold_left = 0;

    fm_index_backward_search_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_address      (s_address),
        .s_symbol       (s_symbol),
        .s_sample_value (s_sample_value),
        .s_base         (s_base),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_range_low    (m_range_low),
        .m_range_high   (m_range_high),
        .m_is_empty     (m_is_empty)
    );

    always #10 aclk = ~aclk;

    // C(b): number of text symbols that sort below base b.
    function automatic int unsigned rows_below(input int unsigned b);
        int unsigned s;
        s = 0;
        for (int k = 0; k < NUM_BASES; k++) begin
            if (k < b) s += base_count[k];
        end
        return s;
    endfunction

    function automatic int unsigned eff_spacing();
        if (spacing_reg == 0) return 1;
        if (spacing_reg > MAX_SPACING) return MAX_SPACING;
        return spacing_reg;
    endfunction

    function automatic int unsigned clamp_row(input longint unsigned v);
        return (v > RANGE_MAX) ? RANGE_MAX : int'(v);
    endfunction

    // Occurrences of base b in BWT rows below p: sample plus a short scan.
    function automatic int unsigned occ_before(input int unsigned b, input int unsigned p);
        int unsigned s, idx, v;
        s = eff_spacing();
        idx = p / s;
        v = (idx < SAMPLE_ROWS) ? occ_val[idx * NUM_BASES + b] : 0;
        for (int unsigned r = p - p % s; r < p; r++) begin
            if (r < TEXT_ROWS && bwt_sym[r] == b) v++;
        end
        return v;
    endfunction

    // True when counting at p touches only entries that were loaded.
    function automatic bit occ_is_loaded(input int unsigned b, input int unsigned p);
        int unsigned s, idx;
        s = eff_spacing();
        idx = p / s;
        if (idx < SAMPLE_ROWS && !occ_written[idx * NUM_BASES + b]) return 0;
        for (int unsigned r = p - p % s; r < p; r++) begin
            if (r < TEXT_ROWS && !bwt_written[r]) return 0;
        end
        return 1;
    endfunction

    function automatic bit extend_is_legal(input int unsigned b);
        if (cur_low > cur_high) return 1;
        return occ_is_loaded(b, cur_low) && occ_is_loaded(b, cur_high + 1);
    endfunction

    // Applies one accepted request to the mirror and queues its result.
    function automatic void predict_search(input search_req_t r);
        range_result_t res;
        int unsigned c, nl, nh;
        case (r.command)
            fmbs_pkg::CMD_LOAD_BWT: begin
                bwt_sym[r.address] = r.symbol;
                bwt_written[r.address] = 1'b1;
                return;
            end
            fmbs_pkg::CMD_LOAD_SAMPLE: begin
                if (r.address < SAMPLE_ROWS) begin
                    occ_val[r.address * NUM_BASES + r.base] = r.sample_value;
                    occ_written[r.address * NUM_BASES + r.base] = 1'b1;
                end
                return;
            end
            fmbs_pkg::CMD_START: begin
                cur_low = clamp_row(longint'(rows_below(r.base)) + 1);
                cur_high = clamp_row(rows_below(r.base + 1));
            end
            default: begin
                if (cur_low <= cur_high) begin
                    c = rows_below(r.base);
                    nl = clamp_row(longint'(c) + occ_before(r.base, cur_low) + 1);
                    nh = clamp_row(longint'(c) + occ_before(r.base, cur_high + 1));
                    cur_low = nl;
                    cur_high = nh;
                end
            end
        endcase
        res.range_low = cur_low[16:0];
        res.range_high = cur_high[16:0];
        res.is_empty = (cur_low > cur_high);
        expected_ranges.push_back(res);
    endfunction

    // Offers one request, with an occasional gap first, and waits for it.
    task automatic send_request(input search_req_t r);
        if (!steady_flow && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= r.command;
        s_address <= r.address;
        s_symbol <= r.symbol;
        s_sample_value <= r.sample_value;
        s_base <= r.base;
        do @(posedge aclk); while (!s_ready);
        predict_search(r);
    endtask

    task automatic send_cmd(input fmbs_pkg::fmbs_command_t cmd, input int unsigned addr,
                            input int unsigned sym, input int unsigned val,
                            input int unsigned b);
        search_req_t r;
        r.command = cmd;
        r.address = addr[15:0];
        r.symbol = sym[2:0];
        r.sample_value = val[16:0];
        r.base = b[1:0];
        send_request(r);
    endtask

    // Sends an extend when it reads only loaded entries, a start otherwise.
    task automatic send_extend(input int unsigned b);
        if (extend_is_legal(b)) begin
            send_cmd(fmbs_pkg::CMD_EXTEND, $urandom, $urandom, $urandom, b);
        end else begin
            send_cmd(fmbs_pkg::CMD_START, $urandom, $urandom, $urandom, b);
        end
    endtask

    // Stops offering and waits for every result, plus a settling margin.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (expected_ranges.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_registers(input int unsigned ca, input int unsigned cc,
                                   input int unsigned cg, input int unsigned ct,
                                   input int unsigned sp);
        int unsigned vals [5];
        vals = '{ca, cc, cg, ct, sp};
        for (int k = 0; k < 5; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= k[2:0];
            cfg_wr_data <= vals[k][15:0];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        for (int k = 0; k < NUM_BASES; k++) base_count[k] = vals[k] & 16'hFFFF;
        spacing_reg = sp & 8'hFF;
    endtask

    // Edge cases on fresh state: empty ranges, odd symbols, ignored loads.
    task automatic test_directed();
        for (int b = 0; b < NUM_BASES; b++) send_cmd(fmbs_pkg::CMD_START, 0, 0, 0, b);
        send_cmd(fmbs_pkg::CMD_EXTEND, 0, 0, 0, 2);
        send_cmd(fmbs_pkg::CMD_LOAD_BWT, 16'hFFFF, 7, 0, 0);
        send_cmd(fmbs_pkg::CMD_LOAD_BWT, 200, 5, 0, 0);
        send_cmd(fmbs_pkg::CMD_LOAD_SAMPLE, 16'hFFFF, 0, 65536, 3);
        send_cmd(fmbs_pkg::CMD_LOAD_SAMPLE, SAMPLE_ROWS, 0, 65536, 1);
        for (int b = 0; b < NUM_BASES; b++) begin
            send_cmd(fmbs_pkg::CMD_LOAD_SAMPLE, SAMPLE_ROWS - 1, 0,
                     (b == 0) ? 65536 : b, b);
        end
        wait_for_idle();
    endtask

    // Full counts push range ends past the range width and must saturate.
    task automatic test_saturation();
        write_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        for (int b = 0; b < NUM_BASES; b++) begin
            send_cmd(fmbs_pkg::CMD_START, 0, 0, 0, b);
            send_extend(3 - b);
        end
        wait_for_idle();
    endtask

    // A small text with a terminator and a couple of odd symbol codes.
    task automatic load_text(output int unsigned counts [NUM_BASES]);
        int unsigned sym;
        for (int k = 0; k < NUM_BASES; k++) counts[k] = 0;
        for (int r = 0; r < TEXT_LEN; r++) begin
            if (r == 17) sym = 4;
            else if (r == 40) sym = 5;
            else if (r == 51) sym = 6;
            else sym = $urandom_range(0, 3);
            if (sym < NUM_BASES) counts[sym]++;
            send_cmd(fmbs_pkg::CMD_LOAD_BWT, r, sym, 0, 0);
        end
    endtask

    // Loads correct samples for the current spacing over the text.
    task automatic load_samples();
        int unsigned s, v;
        s = eff_spacing();
        for (int unsigned idx = 0; idx * s <= TEXT_LEN; idx++) begin
            for (int b = 0; b < NUM_BASES; b++) begin
                v = 0;
                for (int unsigned r = 0; r < idx * s && r < TEXT_LEN; r++) begin
                    if (bwt_sym[r] == b) v++;
                end
                send_cmd(fmbs_pkg::CMD_LOAD_SAMPLE, idx, 0, v, b);
            end
        end
    endtask

    // Mostly start-then-extend walks, with noise loads and stray commands.
    task automatic run_queries(input int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 80) begin
                send_cmd(fmbs_pkg::CMD_START, $urandom, $urandom, $urandom,
                         $urandom_range(0, 3));
                sent++;
                repeat ($urandom_range(1, 6)) begin
                    send_extend($urandom_range(0, 3));
                    sent++;
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: send_cmd(fmbs_pkg::CMD_LOAD_BWT, $urandom_range(TEXT_LEN, 65535),
                                $urandom_range(0, 7), $urandom, $urandom);
                    1: send_cmd(fmbs_pkg::CMD_LOAD_SAMPLE, $urandom_range(0, 65535),
                                $urandom, $urandom_range(0, 65536), $urandom_range(0, 3));
                    2: send_cmd(fmbs_pkg::CMD_LOAD_SAMPLE, $urandom_range(0, 3), $urandom,
                                $urandom_range(0, 65536), $urandom_range(0, 3));
                    default: send_extend($urandom_range(0, 3));
                endcase
                sent++;
            end
        end
        wait_for_idle();
    endtask

    // The receiver holds off for a long stretch while queries keep coming,
    // so the output register fills and the core stops taking requests.
    task automatic test_backpressure();
        hold_request = 300;
        for (int k = 0; k < 20; k++) begin
            send_cmd(fmbs_pkg::CMD_START, 0, 0, 0, k % 4);
            send_extend($urandom_range(0, 3));
        end
        wait_for_idle();
    endtask

    // Receiver: random idling, no idling during steady stretches, and a
    // hold-off counted down here when the sender side asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady_flow || ($urandom_range(99) >= 11);
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        range_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ranges.size() == 0) begin
                $error("unexpected result low=%0d high=%0d empty=%0b",
                       m_range_low, m_range_high, m_is_empty);
                fail_count++;
            end else begin
                want = expected_ranges.pop_front();
                if (m_range_low !== want.range_low) begin
                    $error("range_low expected %0d actual %0d", want.range_low, m_range_low);
                    fail_count++;
                end
                if (m_range_high !== want.range_high) begin
                    $error("range_high expected %0d actual %0d",
                           want.range_high, m_range_high);
                    fail_count++;
                end
                if (m_is_empty !== want.is_empty) begin
                    $error("is_empty expected %0b actual %0b", want.is_empty, m_is_empty);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned counts [NUM_BASES];
        int unsigned phase_spacing [7];
        phase_spacing = '{32, 1, 7, 128, 0, 255, 16};
        cfg_wr_en = 1'b0;
        cfg_index = fmbs_pkg::REG_COUNT_A;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_command = fmbs_pkg::CMD_LOAD_BWT;
        s_address = '0;
        s_symbol = '0;
        s_sample_value = '0;
        s_base = '0;
        cur_low = 0;
        cur_high = 0;
        for (int k = 0; k < NUM_BASES; k++) base_count[k] = 0;
        spacing_reg = 32;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_saturation();
        write_registers(0, 0, 0, 0, 32);
        load_text(counts);
        wait_for_idle();
        for (int p = 0; p < 7; p++) begin
            write_registers(counts[0], counts[1], counts[2], counts[3], phase_spacing[p]);
            load_samples();
            // One phase runs with no idling on either side.
            steady_flow = (p == 2);
            run_queries(30);
            steady_flow = 1'b0;
        end
        test_backpressure();

        wait_for_idle();
        repeat (400) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
